/* rtl/smooth_number_enumerator_defines.svh */
// Assertion macros shared by the checker of the smooth number enumerator.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SMOOTH_NUMBER_ENUMERATOR_DEFINES_SVH
`define SMOOTH_NUMBER_ENUMERATOR_DEFINES_SVH

// Implication in the same cycle, disabled while reset is low.
`define SNE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle, disabled while reset is low.
`define SNE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sne_pkg.sv */
// Shared types and constants of the smooth number enumerator.
// No dependencies; used by every module of the block.
package sne_pkg;

    localparam int MAX_FACTORS_DEF   = 8;
    localparam int HISTORY_DEPTH_DEF = 1024;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_LOAD    = 2'd0;
    localparam t_op OP_RESTART = 2'd1;
    localparam t_op OP_NEXT    = 2'd2;

    localparam t_status ST_NUMBER    = 3'd0;
    localparam t_status ST_ACK       = 3'd1;
    localparam t_status ST_EXHAUSTED = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_BAD       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd1;

    localparam logic [DATA_W-1:0] LOWER_RESET = 32'd1;
    localparam logic [DATA_W-1:0] UPPER_RESET = 32'd1000;
    localparam logic [DATA_W-1:0] MIN_FACTOR  = 32'd2;
    localparam logic [DATA_W-1:0] FIRST_NUM   = 32'd1;

    typedef struct packed {
        logic load;
        logic init;
        logic upd;
    } t_fb_cmd;

endpackage

/* rtl/smooth_number_enumerator.sv */
// Top level of the smooth number enumerator: stream ports, configuration and sequencer.
// Depends on sne_pkg, sne_history_mem and sne_factor_bank.
//
// The block takes one item at a time. A load, restart or unused op goes through the finishing
// state into the output register, and the block is ready for the next item in the same cycle
// as that result appears. A request for the next number reads history entries in turn until
// one lies in range or above the upper bound; past the end of the history it generates a new
// number by a minimum scan over the loaded factors, writes it to the history and runs an update
// pass over the factors, with a multiply for each factor whose candidate advances (its history
// read feeds the multiplier). The history memory has a single read port and the factors share
// one multiplier. A finished result waits in an output register, so the next item is taken
// while it is still unread, and holds in its finishing state while an earlier result is unread.
module smooth_number_enumerator #(
    parameter int MAX_FACTORS   = sne_pkg::MAX_FACTORS_DEF,
    parameter int HISTORY_DEPTH = sne_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sne_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sne_pkg::DATA_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [sne_pkg::DATA_W-1:0]    i_s_axis_tdata,   // [31:0] factor_value
    input  logic [sne_pkg::OP_W-1:0]      i_s_axis_tuser,   // [1:0] op
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [sne_pkg::DATA_W-1:0]    o_m_axis_tdata,   // [31:0] number
    output logic [sne_pkg::STATUS_W-1:0]  o_m_axis_tuser    // [2:0] status
);

    localparam int IW = $clog2(MAX_FACTORS);
    localparam int CW = $clog2(MAX_FACTORS + 1);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int LW = $clog2(HISTORY_DEPTH + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_EMIT_EVAL = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_SCAN_END  = 3'd4;
    localparam logic [2:0] S_UPD_CHK   = 3'd5;
    localparam logic [2:0] S_UPD_MUL   = 3'd6;
    localparam logic [2:0] S_FIN       = 3'd7;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [LW-1:0]                r_len;
    logic [LW-1:0]                r_emit;
    logic                         r_fin;
    logic                         r_out_valid;
    logic [sne_pkg::DATA_W-1:0]   r_lower;
    logic [sne_pkg::DATA_W-1:0]   r_upper;
    logic [IW-1:0]                r_k;
    logic [sne_pkg::PROD_W-1:0]   r_best;
    logic [HW-1:0]                r_hp;
    logic [sne_pkg::DATA_W-1:0]   r_res_num;
    sne_pkg::t_status             r_res_st;
    logic [sne_pkg::DATA_W-1:0]   r_out_data;
    sne_pkg::t_status             r_out_user;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic                         w_load_ok;
    logic                         w_emit_avail;
    logic                         w_h_over;
    logic                         w_h_ok;
    logic                         w_best_over;
    logic                         w_full;
    logic                         w_match;
    logic                         w_k_last;
    logic [LW-1:0]                w_hp_ext;
    logic [HW-1:0]                w_hp;

    logic                         w_hist_we;
    logic [HW-1:0]                w_hist_waddr;
    logic [sne_pkg::DATA_W-1:0]   w_hist_wdata;
    logic [HW-1:0]                w_hist_raddr;
    logic [sne_pkg::DATA_W-1:0]   w_hist_rdata;
    sne_pkg::t_fb_cmd             w_cmd;
    logic [CW-1:0]                w_count;
    logic [sne_pkg::PROD_W-1:0]   w_pending;
    logic [HW-1:0]                w_head;

    sne_history_mem #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rdata)
    );

    sne_factor_bank #(
        .MAX_FACTORS  (MAX_FACTORS),
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_fb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_idx        (r_k),
        .i_load_value (i_s_axis_tdata),
        .i_hp         (r_hp),
        .i_hist_data  (w_hist_rdata),
        .o_count      (w_count),
        .o_pending    (w_pending),
        .o_head       (w_head)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_load_ok       = (i_s_axis_tdata >= sne_pkg::MIN_FACTOR)
                             && (w_count < CW'(MAX_FACTORS));
    assign w_emit_avail    = (r_emit < r_len);
    assign w_h_over        = (w_hist_rdata > r_upper);
    assign w_h_ok          = (w_hist_rdata >= r_lower);
    assign w_best_over     = (r_best > {{sne_pkg::DATA_W{1'b0}}, r_upper});
    assign w_full          = (r_len >= LW'(HISTORY_DEPTH));
    assign w_match         = (w_pending == r_best);
    assign w_k_last        = ((CW'(r_k) + CW'(1)) == w_count);

    // Next head pointer, held at the newest history entry.
    always_comb begin
        w_hp_ext = LW'(w_head) + LW'(1);
        if (w_hp_ext >= r_len) begin
            w_hp_ext = r_len - LW'(1);
        end
        w_hp = w_hp_ext[HW-1:0];
    end

    always_comb begin
        w_hist_we    = 1'b0;
        w_hist_waddr = r_len[HW-1:0];
        w_hist_wdata = r_best[sne_pkg::DATA_W-1:0];
        w_hist_raddr = r_emit[HW-1:0];
        w_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_s_axis_tuser == sne_pkg::OP_NEXT && r_len == '0) begin
                    w_hist_we    = 1'b1;
                    w_hist_waddr = '0;
                    w_hist_wdata = sne_pkg::FIRST_NUM;
                    w_cmd.init   = 1'b1;
                end
                if (w_in_acc && i_s_axis_tuser == sne_pkg::OP_LOAD && w_load_ok) begin
                    w_cmd.load = 1'b1;
                end
            end
            S_SCAN_END: w_hist_we = !w_best_over && !w_full;
            S_UPD_CHK:  w_hist_raddr = w_hp;
            S_UPD_MUL:  w_cmd.upd = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_s_axis_tuser == sne_pkg::OP_NEXT) ? S_CHECK : S_FIN;
                end
            end
            S_CHECK: begin
                if (r_fin) begin
                    n_state = S_FIN;
                end else if (w_emit_avail) begin
                    n_state = S_EMIT_EVAL;
                end else if (w_count == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_EMIT_EVAL: n_state = (w_h_over || w_h_ok) ? S_FIN : S_CHECK;
            S_SCAN:      n_state = w_k_last ? S_SCAN_END : S_SCAN;
            S_SCAN_END:  n_state = (w_best_over || w_full) ? S_FIN : S_UPD_CHK;
            S_UPD_CHK: begin
                if (w_match) begin
                    n_state = S_UPD_MUL;
                end else if (w_k_last) begin
                    n_state = S_CHECK;
                end
            end
            S_UPD_MUL:   n_state = w_k_last ? S_CHECK : S_UPD_CHK;
            S_FIN:       n_state = w_out_free ? S_IDLE : S_FIN;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_emit      <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            r_lower     <= sne_pkg::LOWER_RESET;
            r_upper     <= sne_pkg::UPPER_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    sne_pkg::REG_LOWER: r_lower <= i_cfg_wdata;
                    sne_pkg::REG_UPPER: r_upper <= i_cfg_wdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_s_axis_tuser)
                            sne_pkg::OP_LOAD: begin
                                if (w_load_ok) begin
                                    r_len  <= '0;
                                    r_emit <= '0;
                                    r_fin  <= 1'b0;
                                end
                            end
                            sne_pkg::OP_RESTART: begin
                                r_len  <= '0;
                                r_emit <= '0;
                                r_fin  <= 1'b0;
                            end
                            sne_pkg::OP_NEXT: begin
                                if (r_len == '0) begin
                                    r_len  <= LW'(1);
                                    r_emit <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK: begin
                    if (!r_fin && !w_emit_avail && w_count == '0) begin
                        r_fin <= 1'b1;
                    end
                end
                S_EMIT_EVAL: begin
                    if (w_h_over) begin
                        r_fin <= 1'b1;
                    end else begin
                        r_emit <= r_emit + LW'(1);
                    end
                end
                S_SCAN_END: begin
                    if (w_best_over) begin
                        r_fin <= 1'b1;
                    end else if (!w_full) begin
                        r_len <= r_len + LW'(1);
                    end
                end
                default: ;
            endcase
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_res_num <= '0;
                    case (i_s_axis_tuser)
                        sne_pkg::OP_LOAD:
                            r_res_st <= w_load_ok ? sne_pkg::ST_ACK : sne_pkg::ST_BAD;
                        sne_pkg::OP_RESTART: r_res_st <= sne_pkg::ST_ACK;
                        default:             r_res_st <= sne_pkg::ST_BAD;
                    endcase
                end
            end
            S_CHECK: begin
                r_res_num <= '0;
                r_res_st  <= sne_pkg::ST_EXHAUSTED;
                r_k       <= '0;
            end
            S_EMIT_EVAL: begin
                if (!w_h_over) begin
                    r_res_num <= w_hist_rdata;
                    r_res_st  <= sne_pkg::ST_NUMBER;
                end
            end
            S_SCAN: begin
                if (r_k == '0 || w_pending < r_best) begin
                    r_best <= w_pending;
                end
                if (!w_k_last) begin
                    r_k <= r_k + IW'(1);
                end
            end
            S_SCAN_END: begin
                r_k <= '0;
                if (!w_best_over && w_full) begin
                    r_res_st <= sne_pkg::ST_FULL;
                end
            end
            S_UPD_CHK: begin
                if (w_match) begin
                    r_hp <= w_hp;
                end else if (!w_k_last) begin
                    r_k <= r_k + IW'(1);
                end
            end
            S_UPD_MUL: begin
                if (!w_k_last) begin
                    r_k <= r_k + IW'(1);
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out_data <= r_res_num;
                    r_out_user <= r_res_st;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

/* rtl/sne_history_mem.sv */
// History memory of generated numbers: one write port, one registered read port.
// Depends on sne_pkg for the data width.
module sne_history_mem #(
    parameter int HISTORY_DEPTH = sne_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_waddr,
    input  logic [sne_pkg::DATA_W-1:0]       i_wdata,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_raddr,
    output logic [sne_pkg::DATA_W-1:0]       o_rdata
);

    logic [sne_pkg::DATA_W-1:0] r_mem [HISTORY_DEPTH];
    logic [sne_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sne_factor_bank.sv */
// Factor table with per-factor head pointer and pending candidate, plus the multiplier.
// Depends on sne_pkg for widths and the command struct.
module sne_factor_bank #(
    parameter int MAX_FACTORS   = sne_pkg::MAX_FACTORS_DEF,
    parameter int HISTORY_DEPTH = sne_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sne_pkg::t_fb_cmd                 i_cmd,
    input  logic [$clog2(MAX_FACTORS)-1:0]   i_idx,
    input  logic [sne_pkg::DATA_W-1:0]       i_load_value,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_hp,
    input  logic [sne_pkg::DATA_W-1:0]       i_hist_data,
    output logic [$clog2(MAX_FACTORS+1)-1:0] o_count,
    output logic [sne_pkg::PROD_W-1:0]       o_pending,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_head
);

    localparam int IW = $clog2(MAX_FACTORS);
    localparam int CW = $clog2(MAX_FACTORS + 1);
    localparam int HW = $clog2(HISTORY_DEPTH);

    logic [CW-1:0]                r_count;
    logic [sne_pkg::DATA_W-1:0]   r_factor  [MAX_FACTORS];
    logic [HW-1:0]                r_head    [MAX_FACTORS];
    logic [sne_pkg::PROD_W-1:0]   r_pending [MAX_FACTORS];
    logic [sne_pkg::PROD_W-1:0]   w_prod;

    assign w_prod = sne_pkg::PROD_W'(r_factor[i_idx]) * sne_pkg::PROD_W'(i_hist_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_factor[r_count[IW-1:0]] <= i_load_value;
        end
        if (i_cmd.init) begin
            for (int k = 0; k < MAX_FACTORS; k++) begin
                r_head[k]    <= '0;
                r_pending[k] <= {{sne_pkg::DATA_W{1'b0}}, r_factor[k]};
            end
        end else if (i_cmd.upd) begin
            r_head[i_idx]    <= i_hp;
            r_pending[i_idx] <= w_prod;
        end
    end

    assign o_count   = r_count;
    assign o_pending = r_pending[i_idx];
    assign o_head    = r_head[i_idx];

endmodule

/* rtl/sne_checker.sv */
// Port-level checker of the smooth number enumerator and its bind to the top level.
// Depends on sne_pkg and smooth_number_enumerator_defines.svh.
`include "smooth_number_enumerator_defines.svh"

module sne_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [sne_pkg::DATA_W-1:0]   o_m_axis_tdata,
    input logic [sne_pkg::STATUS_W-1:0] o_m_axis_tuser
);

    // A result that is not taken holds its value.
    `SNE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // Only one item is at work at a time.
    `SNE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "item accepted while busy")

    // Any status other than a number carries a zero value.
    `SNE_ASSERT_SAME(a_zero_num, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser != sne_pkg::ST_NUMBER, o_m_axis_tdata == '0, "non-number result carries data")

    // The status is always a defined code.
    `SNE_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser <= sne_pkg::ST_BAD, "undefined status code")

endmodule

bind smooth_number_enumerator sne_checker u_sne_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench of smooth_number_enumerator: directed table, then random runs.
// Depends on sne_pkg and the RTL top level; expected answers come from the directed table or a predictor kept here.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            NFAC          = sne_pkg::MAX_FACTORS_DEF;
    localparam int            HIST_DEPTH    = sne_pkg::HISTORY_DEPTH_DEF;
    localparam int            RANDOM_ITEMS  = 1000;
    localparam int            CYCLE_LIMIT   = 20_000_000;
    localparam int            DRAIN_CYCLES  = 40;
    localparam int            MAX_PRINTS    = 100;
    localparam sne_pkg::t_op  OP_UNUSED     = 2'd3;

    typedef struct packed {
        logic [sne_pkg::DATA_W-1:0] number;
        sne_pkg::t_status           status;
    } t_answer;

    typedef struct packed {
        sne_pkg::t_op               op;
        logic [sne_pkg::DATA_W-1:0] data;
        logic                       typed;
        logic [sne_pkg::DATA_W-1:0] number;
        sne_pkg::t_status           status;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b1, 32'd1, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'hFFFF_FFFF, 1'b1, 32'd0, sne_pkg::ST_EXHAUSTED},
        '{OP_UNUSED,           32'hFFFF_FFFF, 1'b1, 32'd0, sne_pkg::ST_BAD},
        '{sne_pkg::OP_LOAD,    32'h0000_0000, 1'b1, 32'd0, sne_pkg::ST_BAD},
        '{sne_pkg::OP_LOAD,    32'h0000_0001, 1'b1, 32'd0, sne_pkg::ST_BAD},
        '{sne_pkg::OP_NEXT,    32'h1234_5678, 1'b1, 32'd0, sne_pkg::ST_EXHAUSTED},
        '{sne_pkg::OP_LOAD,    32'h0000_0002, 1'b1, 32'd0, sne_pkg::ST_ACK},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b1, 32'd1, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b1, 32'd2, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_LOAD,    32'h0000_0003, 1'b1, 32'd0, sne_pkg::ST_ACK},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b1, 32'd1, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_RESTART, 32'hAAAA_5555, 1'b1, 32'd0, sne_pkg::ST_ACK},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b1, 32'd1, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_LOAD,    32'h0000_0003, 1'b1, 32'd0, sne_pkg::ST_ACK},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_LOAD,    32'hFFFF_FFFF, 1'b1, 32'd0, sne_pkg::ST_ACK},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b1, 32'd1, sne_pkg::ST_NUMBER},
        '{sne_pkg::OP_NEXT,    32'h0000_0000, 1'b0, 32'd0, sne_pkg::ST_NUMBER}
    };

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_wr_en     = 1'b0;
    logic [sne_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [sne_pkg::DATA_W-1:0]    i_cfg_wdata     = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [sne_pkg::DATA_W-1:0]    i_s_axis_tdata  = '0;
    logic [sne_pkg::OP_W-1:0]      i_s_axis_tuser  = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [sne_pkg::DATA_W-1:0]    o_m_axis_tdata;
    logic [sne_pkg::STATUS_W-1:0]  o_m_axis_tuser;

    smooth_number_enumerator dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state.
    logic [sne_pkg::DATA_W-1:0] lo_bound;
    logic [sne_pkg::DATA_W-1:0] hi_bound;
    logic [sne_pkg::DATA_W-1:0] fac_tab [NFAC];
    int                         fac_cnt;
    logic [sne_pkg::DATA_W-1:0] hist [HIST_DEPTH];
    int                         hist_len;
    int                         head_idx [NFAC];
    logic [sne_pkg::PROD_W-1:0] cand [NFAC];
    int                         emit_idx;
    bit                         run_done;

    t_answer answer_q [$];
    int      err_cnt = 0;
    int      items_sent = 0;
    int      status_seen [5] = '{default: 0};
    int      cycles = 0;
    bit      calm;

    function automatic void clear_run();
        hist_len = 0;
        emit_idx = 0;
        run_done = 1'b0;
        for (int k = 0; k < NFAC; k++) begin
            head_idx[k] = 0;
            cand[k]     = '0;
        end
    endfunction

    function automatic sne_pkg::t_status gen_next(output logic [sne_pkg::DATA_W-1:0] value);
        logic [sne_pkg::PROD_W-1:0] best;
        logic [sne_pkg::DATA_W-1:0] h;
        bit                         any;
        int                         hp;
        value = '0;
        if (hist_len == 0) begin
            hist[0]  = sne_pkg::FIRST_NUM;
            hist_len = 1;
            emit_idx = 0;
            for (int k = 0; k < fac_cnt; k++) begin
                head_idx[k] = 0;
                cand[k]     = {32'd0, fac_tab[k]};
            end
        end
        forever begin
            if (run_done) return sne_pkg::ST_EXHAUSTED;
            if (emit_idx < hist_len) begin
                h = hist[emit_idx];
                if (h > hi_bound) begin
                    run_done = 1'b1;
                    return sne_pkg::ST_EXHAUSTED;
                end
                emit_idx++;
                if (h >= lo_bound) begin
                    value = h;
                    return sne_pkg::ST_NUMBER;
                end
                continue;
            end
            best = '0;
            any  = 1'b0;
            for (int k = 0; k < fac_cnt; k++) begin
                if (!any || cand[k] < best) begin
                    best = cand[k];
                    any  = 1'b1;
                end
            end
            if (!any || best > {32'd0, hi_bound}) begin
                run_done = 1'b1;
                return sne_pkg::ST_EXHAUSTED;
            end
            if (hist_len >= HIST_DEPTH) return sne_pkg::ST_FULL;
            hist[hist_len] = best[sne_pkg::DATA_W-1:0];
            hist_len++;
            for (int k = 0; k < fac_cnt; k++) begin
                if (cand[k] == best) begin
                    hp = head_idx[k] + 1;
                    if (hp >= hist_len) hp = hist_len - 1;
                    head_idx[k] = hp;
                    cand[k] = {32'd0, fac_tab[k]} * {32'd0, hist[hp]};
                end
            end
        end
    endfunction

    function automatic t_answer predict_answer(input sne_pkg::t_op op,
                                               input logic [sne_pkg::DATA_W-1:0] fv);
        t_answer                    a;
        logic [sne_pkg::DATA_W-1:0] num;
        a.number = '0;
        case (op)
            sne_pkg::OP_LOAD: begin
                if (fv < sne_pkg::MIN_FACTOR || fac_cnt >= NFAC) begin
                    a.status = sne_pkg::ST_BAD;
                end else begin
                    fac_tab[fac_cnt] = fv;
                    fac_cnt++;
                    clear_run();
                    a.status = sne_pkg::ST_ACK;
                end
            end
            sne_pkg::OP_RESTART: begin
                clear_run();
                a.status = sne_pkg::ST_ACK;
            end
            sne_pkg::OP_NEXT: begin
                a.status = gen_next(num);
                if (a.status == sne_pkg::ST_NUMBER) a.number = num;
            end
            default: begin
                a.status = sne_pkg::ST_BAD;
            end
        endcase
        return a;
    endfunction

    function automatic logic [sne_pkg::DATA_W-1:0] draw_factor();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(2, 13);
        if (pick == 7) return $urandom_range(0, 1);
        if (pick == 8) return $urandom;
        return $urandom_range(14, 1000);
    endfunction

    task automatic report_mismatch(input string what, input logic [sne_pkg::DATA_W-1:0] got,
                                   input logic [sne_pkg::DATA_W-1:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        err_cnt++;
    endtask

    task automatic send_item(input sne_pkg::t_op op, input logic [sne_pkg::DATA_W-1:0] data,
                             input bit typed, input t_answer typed_ans);
        int      gap;
        t_answer ans;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ans = predict_answer(op, data);
        answer_q.push_back(typed ? typed_ans : ans);
        items_sent++;
    endtask

    task automatic send_plain(input sne_pkg::t_op op, input logic [sne_pkg::DATA_W-1:0] data);
        send_item(op, data, 1'b0, '0);
    endtask

    // The block is idle once every answer is back; the bounds are rewritten only then.
    task automatic write_bounds(input logic [sne_pkg::DATA_W-1:0] lo,
                                input logic [sne_pkg::DATA_W-1:0] hi);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sne_pkg::REG_LOWER;
        i_cfg_wdata <= lo;
        @(negedge i_clk);
        i_cfg_index <= sne_pkg::REG_UPPER;
        i_cfg_wdata <= hi;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lo_bound = lo;
        hi_bound = hi;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("smooth_number_enumerator regression: fail");
            $finish;
        end
    end

    initial begin
        t_answer expd;
        int      gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 4);
            @(negedge i_clk);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            if (o_m_axis_tuser <= sne_pkg::ST_BAD) status_seen[o_m_axis_tuser]++;
            if (answer_q.size() == 0) begin
                report_mismatch("item with nothing pending, number", o_m_axis_tdata, '0);
            end else begin
                expd = answer_q.pop_front();
                if (o_m_axis_tdata !== expd.number)
                    report_mismatch("number", o_m_axis_tdata, expd.number);
                if (o_m_axis_tuser !== expd.status)
                    report_mismatch("status", {29'd0, o_m_axis_tuser}, {29'd0, expd.status});
            end
        end
    end

    initial begin
        int                         kind;
        int                         len;
        int                         pick;
        int                         run_idx;
        logic [sne_pkg::DATA_W-1:0] lo;
        logic [sne_pkg::DATA_W-1:0] hi;
        calm     = 1'b0;
        lo_bound = sne_pkg::LOWER_RESET;
        hi_bound = sne_pkg::UPPER_RESET;
        fac_cnt  = 0;
        for (int k = 0; k < NFAC; k++) fac_tab[k] = '0;
        clear_run();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIR_TAB[r].op, DIR_TAB[r].data, DIR_TAB[r].typed,
                      '{DIR_TAB[r].number, DIR_TAB[r].status});

        run_idx = 0;
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            kind = (run_idx == 0) ? 4 : $urandom_range(0, 5);
            case (kind)
                0: begin lo = sne_pkg::LOWER_RESET; hi = sne_pkg::UPPER_RESET; end
                1: begin lo = 32'd0; hi = 32'hFFFF_FFFF; end
                2: begin lo = $urandom_range(0, 200); hi = $urandom_range(lo, 5000); end
                3: begin hi = $urandom_range(0, 1000); lo = hi + 1 + $urandom_range(0, 100); end
                4: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; end
                default: begin lo = $urandom; hi = $urandom; end
            endcase
            write_bounds(lo, hi);
            calm = ($urandom_range(0, 3) == 0);
            if (run_idx == 0) begin
                send_plain(sne_pkg::OP_LOAD, 32'd5);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 2) send_plain(sne_pkg::OP_LOAD, draw_factor());
                else if (pick < 6) send_plain(sne_pkg::OP_RESTART, $urandom);
            end
            len = (kind == 4) ? 6 : $urandom_range(10, 40);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_plain(sne_pkg::OP_NEXT, $urandom);
                else if (pick < 86 && kind != 4)
                    send_plain(sne_pkg::OP_RESTART, $urandom);
                else if (pick < 93)
                    send_plain(OP_UNUSED, $urandom);
                else
                    send_plain(sne_pkg::OP_LOAD,
                               (fac_cnt >= NFAC) ? $urandom : $urandom_range(0, 1));
            end
            run_idx++;
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items in %0d runs with %0d factors loaded.",
                 items_sent, run_idx, fac_cnt);
        $display("Answers: %0d numbers, %0d acks, %0d exhausted, %0d history full, %0d rejected.",
                 status_seen[sne_pkg::ST_NUMBER], status_seen[sne_pkg::ST_ACK],
                 status_seen[sne_pkg::ST_EXHAUSTED], status_seen[sne_pkg::ST_FULL],
                 status_seen[sne_pkg::ST_BAD]);
        if (err_cnt == 0)
            $display("smooth_number_enumerator regression: pass");
        else
            $display("smooth_number_enumerator regression: fail");
        $finish;
    end

endmodule
